>>> rtl/mts_pkg.sv
// shared types and constants for the timer scheduler table
// no dependencies; imported by every module of the block
package mts_pkg;

    localparam logic [1:0] CMD_REGISTER   = 2'd0;
    localparam logic [1:0] CMD_UNREGISTER = 2'd1;
    localparam logic [1:0] CMD_TICK       = 2'd2;

    localparam logic [1:0] KIND_ASSIGNED = 2'd0;
    localparam logic [1:0] KIND_REFUSED  = 2'd1;
    localparam logic [1:0] KIND_FIRED    = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] now_ms;
        logic [31:0] delay_ms;
        logic        periodic;
        logic [31:0] target_id;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] timer_id;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] period;
        logic [63:0] due;
        logic        repeats;
    } entry_t;

    // what the datapath does with each entry read during a sweep
    typedef enum logic [2:0] {
        MODE_NONE,
        MODE_FREE,
        MODE_UNREG,
        MODE_MARK,
        MODE_SELECT
    } sweep_mode_t;

    typedef struct packed {
        logic        latch;
        logic        sweep_start;
        sweep_mode_t mode;
        logic        reg_finish;
        logic        fire;
    } ctl_cmd_t;

    typedef struct packed {
        logic sweep_done;
        logic count_zero;
    } ctl_sts_t;

    // due time addition, saturating at the top of the 64-bit range
    function automatic logic [63:0] due_add(input logic [63:0] base, input logic [31:0] delta);
        logic [64:0] sum;
        sum = {1'b0, base} + {33'b0, delta};
        return sum[64] ? '1 : sum[63:0];
    endfunction

endpackage

>>> rtl/mts_ctrl.sv
// controller state machine for the timer scheduler table
// depends on mts_pkg for the command and status structs
module mts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        command,
    input  mts_pkg::ctl_sts_t sts,
    output mts_pkg::ctl_cmd_t cmd,
    output logic              busy
);
    import mts_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FREE,
        ST_REG_WRITE,
        ST_UNREG,
        ST_MARK,
        ST_CHECK,
        ST_SELECT,
        ST_FIRE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    always_comb
    begin
        state_next          = state_reg;
        cmd                 = '0;
        cmd.mode            = MODE_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    unique case (command)
                        CMD_REGISTER:
                        begin
                            cmd.sweep_start = 1'b1;
                            state_next      = ST_FREE;
                        end
                        CMD_UNREGISTER:
                        begin
                            cmd.sweep_start = 1'b1;
                            state_next      = ST_UNREG;
                        end
                        CMD_TICK:
                        begin
                            cmd.sweep_start = 1'b1;
                            state_next      = ST_MARK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FREE:
            begin
                cmd.mode = MODE_FREE;
                if (sts.sweep_done)
                begin
                    state_next = ST_REG_WRITE;
                end
            end
            ST_REG_WRITE:
            begin
                cmd.reg_finish = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_UNREG:
            begin
                cmd.mode = MODE_UNREG;
                if (sts.sweep_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MARK:
            begin
                cmd.mode = MODE_MARK;
                if (sts.sweep_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.count_zero)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.sweep_start = 1'b1;
                    state_next      = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                cmd.mode = MODE_SELECT;
                if (sts.sweep_done)
                begin
                    state_next = ST_FIRE;
                end
            end
            ST_FIRE:
            begin
                cmd.fire   = 1'b1;
                state_next = ST_CHECK;
            end
        endcase
        busy_next = (state_next != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

>>> rtl/mts_datapath.sv
// datapath of the timer scheduler table: entry memory, valid and pending bits,
// sweep counter, best-id tracker and result register; depends on mts_pkg
module mts_datapath #(
    parameter int MAX_TIMERS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mts_pkg::req_t     request,
    input  mts_pkg::ctl_cmd_t cmd,
    output mts_pkg::ctl_sts_t sts,
    output logic              strobe,
    output mts_pkg::rsp_t     response
);
    import mts_pkg::*;

    localparam int IDXW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNTW = $clog2(MAX_TIMERS + 1);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(MAX_TIMERS - 1);

    entry_t entry_mem [MAX_TIMERS];

    // control state
    logic [MAX_TIMERS-1:0] valid_reg, valid_next;
    logic [MAX_TIMERS-1:0] pending_reg, pending_next;
    logic [CNTW-1:0]       count_reg, count_next;
    logic [31:0]           next_id_reg, next_id_next;
    logic                  sweep_reg, sweep_next;
    logic [IDXW-1:0]       idx_reg, idx_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic                  best_found_reg, best_found_next;
    logic                  free_found_reg, free_found_next;
    logic                  strobe_reg, strobe_next;

    // payload
    req_t                  req_reg, req_next;
    logic [IDXW-1:0]       rd_idx_reg, rd_idx_next;
    entry_t                rd_data_reg;
    entry_t                best_reg, best_next;
    logic [IDXW-1:0]       best_slot_reg, best_slot_next;
    logic [IDXW-1:0]       free_slot_reg, free_slot_next;
    rsp_t                  rsp_reg, rsp_next;

    logic                  mem_we;
    logic [IDXW-1:0]       mem_addr;
    entry_t                mem_wdata;
    logic                  rd_valid_bit;

    assign rd_valid_bit = valid_reg[rd_idx_reg];

    // memory write: new entry on register, re-armed entry on a periodic fire
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = free_slot_reg;
        mem_wdata = best_reg;
        if (cmd.reg_finish && free_found_reg)
        begin
            mem_we            = 1'b1;
            mem_addr          = free_slot_reg;
            mem_wdata.id      = next_id_reg;
            mem_wdata.period  = req_reg.delay_ms;
            mem_wdata.due     = due_add(req_reg.now_ms, req_reg.delay_ms);
            mem_wdata.repeats = req_reg.periodic;
        end
        else if (cmd.fire && best_reg.repeats)
        begin
            mem_we        = 1'b1;
            mem_addr      = best_slot_reg;
            mem_wdata.due = due_add(req_reg.now_ms, best_reg.period);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= entry_mem[idx_reg];
    end

    always_comb
    begin
        valid_next      = valid_reg;
        pending_next    = pending_reg;
        count_next      = count_reg;
        next_id_next    = next_id_reg;
        sweep_next      = sweep_reg;
        idx_next        = idx_reg;
        rd_vld_next     = sweep_reg;
        rd_idx_next     = idx_reg;
        best_found_next = best_found_reg;
        free_found_next = free_found_reg;
        strobe_next     = 1'b0;
        req_next        = req_reg;
        best_next       = best_reg;
        best_slot_next  = best_slot_reg;
        free_slot_next  = free_slot_reg;
        rsp_next        = rsp_reg;

        if (cmd.latch)
        begin
            req_next        = request;
            count_next      = '0;
            free_found_next = 1'b0;
        end

        // one entry read per cycle, read data comes back through a register
        if (cmd.sweep_start)
        begin
            sweep_next      = 1'b1;
            idx_next        = '0;
            best_found_next = 1'b0;
        end
        else if (sweep_reg)
        begin
            if (idx_reg == LAST_IDX)
            begin
                sweep_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + IDXW'(1);
            end
        end

        if (rd_vld_reg)
        begin
            unique case (cmd.mode)
                MODE_FREE:
                begin
                    if (!rd_valid_bit && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_slot_next  = rd_idx_reg;
                    end
                end
                MODE_UNREG:
                begin
                    if (rd_valid_bit && rd_data_reg.id == req_reg.target_id)
                    begin
                        valid_next[rd_idx_reg] = 1'b0;
                    end
                end
                MODE_MARK:
                begin
                    pending_next[rd_idx_reg] = rd_valid_bit
                                               && (rd_data_reg.due <= req_reg.now_ms);
                    if (rd_valid_bit && (rd_data_reg.due <= req_reg.now_ms))
                    begin
                        count_next = count_reg + CNTW'(1);
                    end
                end
                MODE_SELECT:
                begin
                    // strict compare keeps the lowest slot among equal ids
                    if (pending_reg[rd_idx_reg]
                        && (!best_found_reg || rd_data_reg.id < best_reg.id))
                    begin
                        best_found_next = 1'b1;
                        best_next       = rd_data_reg;
                        best_slot_next  = rd_idx_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.reg_finish)
        begin
            strobe_next = 1'b1;
            if (free_found_reg)
            begin
                valid_next[free_slot_reg] = 1'b1;
                next_id_next  = (next_id_reg == '1) ? 32'd1 : next_id_reg + 32'd1;
                rsp_next.kind     = KIND_ASSIGNED;
                rsp_next.timer_id = next_id_reg;
                rsp_next.last     = 1'b1;
            end
            else
            begin
                rsp_next.kind     = KIND_REFUSED;
                rsp_next.timer_id = '0;
                rsp_next.last     = 1'b1;
            end
        end

        if (cmd.fire)
        begin
            strobe_next                 = 1'b1;
            rsp_next.kind               = KIND_FIRED;
            rsp_next.timer_id           = best_reg.id;
            rsp_next.last               = (count_reg == CNTW'(1));
            pending_next[best_slot_reg] = 1'b0;
            count_next                  = count_reg - CNTW'(1);
            if (!best_reg.repeats)
            begin
                valid_next[best_slot_reg] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            pending_reg    <= '0;
            count_reg      <= '0;
            next_id_reg    <= 32'd1;
            sweep_reg      <= 1'b0;
            idx_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            pending_reg    <= pending_next;
            count_reg      <= count_next;
            next_id_reg    <= next_id_next;
            sweep_reg      <= sweep_next;
            idx_reg        <= idx_next;
            rd_vld_reg     <= rd_vld_next;
            best_found_reg <= best_found_next;
            free_found_reg <= free_found_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        rd_idx_reg    <= rd_idx_next;
        best_reg      <= best_next;
        best_slot_reg <= best_slot_next;
        free_slot_reg <= free_slot_next;
        rsp_reg       <= rsp_next;
    end

    assign sts.sweep_done = rd_vld_reg && (rd_idx_reg == LAST_IDX);
    assign sts.count_zero = (count_reg == '0);
    assign strobe         = strobe_reg;
    assign response       = rsp_reg;

endmodule

>>> rtl/multi_timer_scheduler_table.sv
// top level of the timer scheduler table
// depends on mts_pkg, mts_ctrl and mts_datapath
//
//  channel    handshake        payload     direction
//  request    start / busy     req_t       in   (beat taken when start && !busy)
//  response   strobe           rsp_t       out  (one cycle per beat, cannot stall)
//
// n = MAX_TIMERS. every pass walks the entry memory one slot per cycle (one read port)
// register: a free-slot pass, then the write and the result beat; unregister: a matching pass, no result beat
// tick: a marking pass finds the due set, then a selecting pass per fired timer
// (each fire needs a full pass for the lowest pending id)
// reset empties the table through valid bits at once; no clearing pass
// results leave through an output register with no back-pressure
module multi_timer_scheduler_table #(
    parameter int MAX_TIMERS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  mts_pkg::req_t request,
    output logic          strobe,
    output mts_pkg::rsp_t response
);
    import mts_pkg::*;

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    mts_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (request.command),
        .sts     (sts),
        .cmd     (cmd),
        .busy    (busy)
    );

    mts_datapath #(
        .MAX_TIMERS (MAX_TIMERS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cmd      (cmd),
        .sts      (sts),
        .strobe   (strobe),
        .response (response)
    );

endmodule

>>> rtl/mts_checker.sv
// port-level checks for the timer scheduler table, bound to the top level
// depends on mts_pkg
module mts_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input mts_pkg::req_t request,
    input logic          strobe,
    input mts_pkg::rsp_t response
);
    import mts_pkg::*;

    // a real command keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.command == CMD_REGISTER
                            || request.command == CMD_UNREGISTER
                            || request.command == CMD_TICK)) |=> busy)
        else $error("block not busy after accepting a command");

    // a fresh id is never zero and ends its command
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && response.kind == KIND_ASSIGNED) |-> (response.last && response.timer_id != '0))
        else $error("bad assigned-id beat");

    // a refusal carries id zero and ends its command
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && response.kind == KIND_REFUSED) |-> (response.last && response.timer_id == '0))
        else $error("bad refusal beat");

    // more beats to come keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !response.last) |=> busy)
        else $error("block went idle before the last beat");

endmodule

bind multi_timer_scheduler_table mts_checker u_mts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .strobe   (strobe),
    .response (response)
);

>>> tb/tb_multi_timer_scheduler_table.sv
`timescale 1ns / 1ps
// self-checking testbench for the timer scheduler table: directed and random command beats
// depends on mts_pkg and multi_timer_scheduler_table; keeps its own copy of the timer table
module tb_multi_timer_scheduler_table;
    import mts_pkg::*;

    localparam int N_TIMERS       = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_ITEMS   = 360;
    localparam logic [1:0] CMD_UNDEFINED = 2'd3;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    req_t  request;
    logic  strobe;
    rsp_t  response;

    // timer table as the block should hold it
    bit        tbl_valid   [N_TIMERS];
    bit [31:0] tbl_id      [N_TIMERS];
    bit [31:0] tbl_period  [N_TIMERS];
    bit [63:0] tbl_due     [N_TIMERS];
    bit        tbl_repeats [N_TIMERS];
    bit [31:0] id_counter;

    rsp_t      timer_events[$];
    int        mismatches;
    int        quiet_cycles = 0;
    bit [63:0] wall_ms;
    int        burst_left;

    multi_timer_scheduler_table #(.MAX_TIMERS(N_TIMERS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .strobe(strobe),
        .response(response)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic bit [63:0] due_after(input bit [63:0] base, input bit [31:0] span);
        bit [64:0] total;
        total = {1'b0, base} + {33'b0, span};
        return total[64] ? 64'hFFFF_FFFF_FFFF_FFFF : total[63:0];
    endfunction

    function automatic rsp_t make_event(input logic [1:0] kind, input logic [31:0] id,
                                        input logic last);
        rsp_t ev;
        ev.kind     = kind;
        ev.timer_id = id;
        ev.last     = last;
        return ev;
    endfunction

    // queues one expected result beat behind those already waiting
    task automatic expect_beat(input rsp_t ev);
        timer_events.insert(timer_events.size(), ev);
    endtask

    // works out the result beats of one accepted command and updates the table
    task automatic update_timer_table(input req_t r);
        int slot;
        int cnt;
        int best;
        bit due_now [N_TIMERS];
        slot = -1;
        cnt  = 0;
        if (r.command == CMD_REGISTER)
        begin
            for (int i = N_TIMERS - 1; i >= 0; i--)
                if (!tbl_valid[i])
                    slot = i;
            if (slot < 0)
                expect_beat(make_event(KIND_REFUSED, 32'd0, 1'b1));
            else
            begin
                tbl_valid[slot]   = 1'b1;
                tbl_id[slot]      = id_counter;
                tbl_period[slot]  = r.delay_ms;
                tbl_due[slot]     = due_after(r.now_ms, r.delay_ms);
                tbl_repeats[slot] = r.periodic;
                expect_beat(make_event(KIND_ASSIGNED, id_counter, 1'b1));
                id_counter++;
                if (id_counter == 32'd0)
                    id_counter = 32'd1;
            end
        end
        else if (r.command == CMD_UNREGISTER)
        begin
            if (r.target_id != 32'd0)
                for (int i = 0; i < N_TIMERS; i++)
                    if (tbl_valid[i] && tbl_id[i] == r.target_id)
                        tbl_valid[i] = 1'b0;
        end
        else if (r.command == CMD_TICK)
        begin
            // due set is fixed from the table before any re-arm
            for (int i = 0; i < N_TIMERS; i++)
            begin
                due_now[i] = tbl_valid[i] && tbl_due[i] <= r.now_ms;
                if (due_now[i])
                    cnt++;
            end
            for (int k = 0; k < cnt; k++)
            begin
                best = -1;
                for (int i = 0; i < N_TIMERS; i++)
                    if (due_now[i] && (best < 0 || tbl_id[i] < tbl_id[best]))
                        best = i;
                due_now[best] = 1'b0;
                expect_beat(make_event(KIND_FIRED, tbl_id[best], k == cnt - 1));
                if (tbl_repeats[best])
                    tbl_due[best] = due_after(r.now_ms, tbl_period[best]);
                else
                    tbl_valid[best] = 1'b0;
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        rsp_t want;
        if (rst_n && strobe === 1'b1)
        begin
            if (timer_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: kind %0d id %0d last %0d",
                             response.kind, response.timer_id, response.last);
            end
            else
            begin
                want = timer_events.pop_front();
                if (response.kind !== want.kind || response.timer_id !== want.timer_id
                    || response.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected kind %0d id %0d last %0d, got kind %0d id %0d last %0d",
                                 want.kind, want.timer_id, want.last,
                                 response.kind, response.timer_id, response.last);
                end
            end
        end
    end

    // ends the run when neither a command nor a result beat moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // start stays high on return so a following beat can go back to back
    task automatic send_beat(input req_t r);
        @(negedge clk);
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        update_timer_table(r);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (timer_events.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_paced(input req_t r);
        send_beat(r);
        burst_left--;
        if (burst_left <= 0)
        begin
            pause_sender($urandom_range(1, 30));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                      : $urandom_range(1, 8);
        end
    endtask

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic req_t noise_request();
        req_t r;
        r.command   = CMD_UNDEFINED;
        r.now_ms    = rand64();
        r.delay_ms  = $urandom;
        r.periodic  = 1'($urandom_range(0, 1));
        r.target_id = $urandom;
        return r;
    endfunction

    function automatic bit [31:0] live_id();
        int base;
        base = $urandom_range(0, N_TIMERS - 1);
        for (int k = 0; k < N_TIMERS; k++)
            if (tbl_valid[(base + k) % N_TIMERS])
                return tbl_id[(base + k) % N_TIMERS];
        return 32'd0;
    endfunction

    // one-shot and zero-period periodic timers, fired on consecutive ticks
    task automatic test_register_and_fire();
        req_t r;
        r = noise_request();
        r.command  = CMD_REGISTER;
        r.now_ms   = 64'd100;
        r.delay_ms = 32'd0;
        r.periodic = 1'b0;
        send_paced(r);
        r.periodic = 1'b1;
        send_paced(r);
        r = noise_request();
        r.command = CMD_TICK;
        r.now_ms  = 64'd100;
        send_paced(r);
        r.now_ms  = 64'd101;
        send_paced(r);
    endtask

    task automatic test_unregister_cases();
        req_t r;
        r = noise_request();
        send_paced(r);
        r = noise_request();
        r.command   = CMD_UNREGISTER;
        r.target_id = 32'd0;
        send_paced(r);
        r.target_id = 32'hFFFF_FFFF;
        send_paced(r);
        r.target_id = 32'd2;
        send_paced(r);
    endtask

    // fill the table near the top of time, one refusal, then fire every slot at once
    task automatic test_full_table();
        req_t r;
        for (int i = 0; i < N_TIMERS; i++)
        begin
            r = noise_request();
            r.command  = CMD_REGISTER;
            r.now_ms   = 64'hFFFF_FFFF_FFFF_FF00;
            r.delay_ms = (i % 4 == 0) ? 32'hFFFF_FFFF : 32'(i * 8);
            r.periodic = i[0];
            send_paced(r);
        end
        r = noise_request();
        r.command = CMD_REGISTER;
        send_paced(r);
        r = noise_request();
        r.command = CMD_TICK;
        r.now_ms  = 64'hFFFF_FFFF_FFFF_FFFF;
        send_paced(r);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int   counted;
        int   pick;
        int   sub;
        bit   drained;
        req_t r;
        counted = 0;
        drained = 1'b0;
        while (counted < RANDOM_ITEMS)
        begin
            r    = noise_request();
            pick = $urandom_range(0, 99);
            sub  = $urandom_range(0, 99);
            if (pick < 40)
            begin
                r.command = CMD_REGISTER;
                if (sub >= 8)
                    r.now_ms = wall_ms;
                sub = $urandom_range(0, 9);
                if (sub == 0)
                    r.delay_ms = 32'd0;
                else if (sub < 9)
                    r.delay_ms = $urandom_range(1, 60);
                counted++;
            end
            else if (pick < 60)
            begin
                r.command = CMD_UNREGISTER;
                if (sub < 70 && live_id() != 32'd0)
                    r.target_id = live_id();
                else if (sub < 80)
                    r.target_id = 32'd0;
                else if (sub < 90)
                    r.target_id = id_counter - 32'd1;
                if (r.target_id != 32'd0)
                    counted++;
            end
            else if (pick < 96)
            begin
                r.command = CMD_TICK;
                wall_ms   = wall_ms + 64'($urandom_range(0, 40));
                if (sub < 92)
                    r.now_ms = wall_ms;
                else if (sub < 97)
                    r.now_ms = 64'hFFFF_FFFF_FFFF_FFFF;
                counted++;
            end
            send_paced(r);
            // let the block run dry once midway, and now and then at random
            if ((!drained && counted >= RANDOM_ITEMS / 2) || $urandom_range(0, 99) == 0)
            begin
                drained = 1'b1;
                wait_drained();
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        mismatches = 0;
        wall_ms    = 64'd0;
        burst_left = 4;
        id_counter = 32'd1;
        for (int i = 0; i < N_TIMERS; i++)
            tbl_valid[i] = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_register_and_fire();
        test_unregister_cases();
        test_full_table();
        test_random_traffic();

        @(negedge clk);
        start <= 1'b0;
        while (timer_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
